@@ rtl/serial_line_editor_tokenizer_top_assert.svh @@
// Assertion macros for the serial line editor checker.
// Each macro expands to one labelled concurrent assertion clocked on clk, disabled in rst.
`ifndef SERIAL_LINE_EDITOR_TOKENIZER_TOP_ASSERT_SVH
`define SERIAL_LINE_EDITOR_TOKENIZER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SLET_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SLET_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/slet_pkg.sv @@
// Shared types and constants for the serial line editor and tokenizer.
// Used by the front, queue, back, top-level and checker modules; depends on nothing.
`timescale 1ns / 1ps

package slet_pkg;

  // Operation codes of an input item.
  typedef enum logic {
    OP_BYTE  = 1'b0,
    OP_START = 1'b1
  } op_t;

  // Result kinds.
  typedef enum logic {
    KIND_ECHO  = 1'b0,
    KIND_WRITE = 1'b1
  } kind_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_LINE_CAPACITY = 2'd0,
    CFG_KEY_MARKER    = 2'd1,
    CFG_VALUE_MARKER  = 2'd2
  } cfg_reg_t;

  // Quote mode of the open line.
  typedef enum logic [1:0] {
    QUOTE_NONE   = 2'd0,
    QUOTE_SINGLE = 2'd1,
    QUOTE_DOUBLE = 2'd2
  } quote_t;

  localparam logic [7:0] CAPACITY_RESET     = 8'd64;
  localparam logic [7:0] KEY_MARKER_RESET   = 8'd1;
  localparam logic [7:0] VALUE_MARKER_RESET = 8'd2;

  localparam logic [7:0] CH_BS       = 8'd8;
  localparam logic [7:0] CH_LF       = 8'd10;
  localparam logic [7:0] CH_CR       = 8'd13;
  localparam logic [7:0] CH_SPACE    = 8'd32;
  localparam logic [7:0] CH_DQUOTE   = 8'd34;
  localparam logic [7:0] CH_SQUOTE   = 8'd39;
  localparam logic [7:0] CH_PROMPT   = 8'd62;
  localparam logic [7:0] CH_PRINT_LO = 8'd33;
  localparam logic [7:0] CH_PRINT_HI = 8'd126;
  localparam logic [7:0] CH_DEL      = 8'd127;

  // One result item.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [7:0] index;
    logic       done;
  } res_t;

  // All results caused by one input item; slot 0 goes out first.
  typedef struct packed {
    logic [1:0]     count;
    res_t [2:0]     res;
  } job_t;

endpackage

@@ rtl/slet_front.sv @@
// Front part: configuration registers, line state and decoding of each input item
// into a job of up to three results. Depends on slet_pkg.
`timescale 1ns / 1ps

module slet_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                in_valid,
  input  logic                op,
  input  logic [7:0]          rx_byte,
  input  logic                q_full,
  output logic                push,
  output slet_pkg::job_t      push_job
);

  logic [7:0]       line_capacity;
  logic [7:0]       key_marker;
  logic [7:0]       value_marker;

  logic             line_active;
  logic             line_active_next;
  logic [7:0]       fill_index;
  logic [7:0]       fill_index_next;
  slet_pkg::quote_t quote_mode;
  slet_pkg::quote_t quote_mode_next;
  logic [1:0]       spaces_seen;
  logic [1:0]       spaces_seen_next;

  logic             accept;
  logic [7:0]       fill_limit;
  logic [7:0]       fill_inc;
  logic             is_print;
  slet_pkg::quote_t quote_hit;
  slet_pkg::job_t   job;

  function automatic slet_pkg::res_t echo_res(input logic [7:0] b);
    slet_pkg::res_t r;
    r.kind  = slet_pkg::KIND_ECHO;
    r.data  = b;
    r.index = 8'd0;
    r.done  = 1'b0;
    return r;
  endfunction

  function automatic slet_pkg::res_t write_res(input logic [7:0] b, input logic [7:0] idx);
    slet_pkg::res_t r;
    r.kind  = slet_pkg::KIND_WRITE;
    r.data  = b;
    r.index = idx;
    r.done  = 1'b0;
    return r;
  endfunction

  function automatic slet_pkg::res_t term_res(input logic [7:0] idx);
    slet_pkg::res_t r;
    r.kind  = slet_pkg::KIND_WRITE;
    r.data  = 8'd0;
    r.index = idx;
    r.done  = 1'b1;
    return r;
  endfunction

  // Configuration writes are always taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_capacity <= slet_pkg::CAPACITY_RESET;
      key_marker    <= slet_pkg::KEY_MARKER_RESET;
      value_marker  <= slet_pkg::VALUE_MARKER_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        slet_pkg::CFG_LINE_CAPACITY: line_capacity <= cfg_data;
        slet_pkg::CFG_KEY_MARKER:    key_marker    <= cfg_data;
        slet_pkg::CFG_VALUE_MARKER:  value_marker  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept     = in_valid & ~q_full;
  assign fill_limit = (line_capacity == 8'd0) ? 8'd0 : line_capacity - 8'd1;
  assign fill_inc   = fill_index + 8'd1;
  assign is_print   = (rx_byte >= slet_pkg::CH_PRINT_LO) && (rx_byte <= slet_pkg::CH_PRINT_HI);

  // Quote character seen in this byte, if any.
  always_comb begin
    priority if (rx_byte == slet_pkg::CH_SQUOTE) quote_hit = slet_pkg::QUOTE_SINGLE;
    else if (rx_byte == slet_pkg::CH_DQUOTE)     quote_hit = slet_pkg::QUOTE_DOUBLE;
    else                                         quote_hit = slet_pkg::QUOTE_NONE;
  end

  // Decode one item into its results and the line state it leaves behind.
  always_comb begin
    job               = '0;
    line_active_next  = line_active;
    fill_index_next   = fill_index;
    quote_mode_next   = quote_mode;
    spaces_seen_next  = spaces_seen;
    if (op == slet_pkg::OP_START) begin
      line_active_next = 1'b1;
      fill_index_next  = 8'd0;
      quote_mode_next  = slet_pkg::QUOTE_NONE;
      spaces_seen_next = 2'd0;
      job.res[0]       = echo_res(slet_pkg::CH_PROMPT);
      job.res[1]       = echo_res(slet_pkg::CH_SPACE);
      job.count        = 2'd2;
      if (fill_limit == 8'd0) begin
        job.res[2]       = term_res(8'd0);
        job.count        = 2'd3;
        line_active_next = 1'b0;
      end
    end else if (line_active) begin
      priority if (fill_index >= fill_limit) begin
        // Buffer already full, e.g. after the capacity was lowered.
        job.res[0]       = term_res(fill_index);
        job.count        = 2'd1;
        line_active_next = 1'b0;
      end else if (rx_byte == slet_pkg::CH_LF || rx_byte == slet_pkg::CH_CR) begin
        job.res[0]       = term_res(fill_index);
        job.count        = 2'd1;
        line_active_next = 1'b0;
      end else if ((rx_byte == slet_pkg::CH_DEL || rx_byte == slet_pkg::CH_BS) &&
                   fill_index != 8'd0) begin
        job.res[0]      = echo_res(slet_pkg::CH_BS);
        job.res[1]      = echo_res(slet_pkg::CH_SPACE);
        job.res[2]      = echo_res(slet_pkg::CH_BS);
        job.count       = 2'd3;
        fill_index_next = fill_index - 8'd1;
      end else if (!rx_byte[7]) begin
        if (quote_hit != slet_pkg::QUOTE_NONE) begin
          if (quote_mode == quote_hit) begin
            quote_mode_next = slet_pkg::QUOTE_NONE;
          end else if (quote_mode == slet_pkg::QUOTE_NONE) begin
            quote_mode_next = quote_hit;
          end
        end
        if (rx_byte == slet_pkg::CH_SPACE && quote_mode == slet_pkg::QUOTE_NONE) begin
          if (!spaces_seen[1]) begin
            // First or second separator: store the marker, echo the space.
            job.res[0]       = write_res(spaces_seen[0] ? value_marker : key_marker,
                                         fill_index);
            job.res[1]       = echo_res(slet_pkg::CH_SPACE);
            job.count        = 2'd2;
            fill_index_next  = fill_inc;
            spaces_seen_next = spaces_seen + 2'd1;
            if (fill_inc >= fill_limit) begin
              job.res[2]       = term_res(fill_inc);
              job.count        = 2'd3;
              line_active_next = 1'b0;
            end
          end else begin
            job.res[0]       = term_res(fill_index);
            job.count        = 2'd1;
            line_active_next = 1'b0;
          end
        end else if (is_print || rx_byte == slet_pkg::CH_SPACE) begin
          job.res[0]      = echo_res(rx_byte);
          job.res[1]      = write_res(rx_byte, fill_index);
          job.count       = 2'd2;
          fill_index_next = fill_inc;
          if (fill_inc >= fill_limit) begin
            job.res[2]       = term_res(fill_inc);
            job.count        = 2'd3;
            line_active_next = 1'b0;
          end
        end
      end else begin
        // Bytes above 127 are ignored and leave the line as it is.
      end
    end
  end

  // Line state moves on with every accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
      fill_index  <= 8'd0;
      quote_mode  <= slet_pkg::QUOTE_NONE;
      spaces_seen <= 2'd0;
    end else if (accept) begin
      line_active <= line_active_next;
      fill_index  <= fill_index_next;
      quote_mode  <= quote_mode_next;
      spaces_seen <= spaces_seen_next;
    end
  end

  // Items that cause no result are not queued.
  assign push     = accept & (job.count != 2'd0);
  assign push_job = job;

endmodule

@@ rtl/slet_queue.sv @@
// Two-entry job queue between the front and back parts.
// Depends on slet_pkg for the job type.
`timescale 1ns / 1ps

module slet_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  slet_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output slet_pkg::job_t head
);

  slet_pkg::job_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;

  // Storage; no reset needed for payload.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  assign full  = (fill == 2'd2);
  assign valid = (fill != 2'd0);
  assign head  = entries[rd_ptr];

endmodule

@@ rtl/slet_back.sv @@
// Back part: holds the current job, gives one result per cycle unless stalled.
// Depends on slet_pkg for the job and result types.
`timescale 1ns / 1ps

module slet_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  slet_pkg::job_t q_head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           kind,
  output logic [7:0]     out_byte,
  output logic [7:0]     write_index,
  output logic           line_done,
  output logic           last
);

  slet_pkg::job_t job;
  logic           job_valid;
  logic [1:0]     slot;
  logic           out_accept;
  logic           is_last;
  slet_pkg::res_t cur;

  assign out_accept = job_valid & ~out_stall;
  assign is_last    = (slot == job.count - 2'd1);
  assign pop        = q_valid & (~job_valid | (out_accept & is_last));

  // Job register and result slot counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      slot      <= 2'd0;
    end else if (pop) begin
      job_valid <= 1'b1;
      slot      <= 2'd0;
    end else if (out_accept) begin
      if (is_last) begin
        job_valid <= 1'b0;
        slot      <= 2'd0;
      end else begin
        slot <= slot + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= q_head;
    end
  end

  // Select the current result from registered job slots.
  always_comb begin
    unique case (slot)
      2'd0:    cur = job.res[0];
      2'd1:    cur = job.res[1];
      default: cur = job.res[2];
    endcase
  end

  assign out_valid   = job_valid;
  assign kind        = cur.kind;
  assign out_byte    = cur.data;
  assign write_index = cur.index;
  assign line_done   = cur.done;
  assign last        = is_last;

endmodule

@@ rtl/serial_line_editor_tokenizer_top.sv @@
// Console line editor and tokenizer: input item channel, result channel and config port.
// Instantiates slet_front, slet_queue and slet_back; depends on slet_pkg.
//
// Usage:
//   Input items (op, rx_byte) are taken on in_valid with in_stall low. op = start
//   emits the prompt and opens a line; op = byte echoes, stores or edits.
//   Each item causes zero to three result items (kind, out_byte, write_index,
//   line_done, last) on out_valid with out_stall low; last marks the final one.
//   Configuration writes (cfg_index, cfg_data) are always accepted, cfg_ready is high;
//   write them only while no item is in flight.
// Result path: an accepted item is written into the job queue, then loaded into
//   the back part's job register, from which its results are offered.
// Throughput: one result per cycle while out_stall is low, set by the single result
//   port of the back part; the front takes one item per cycle while the queue is
//   not full.
// Reset (rst, synchronous): no line is open, the queue is empty, line_capacity
//   is 64, key_marker 1, value_marker 2.
// Stall: a stalled result holds; the two-entry job queue keeps taking items
//   until it is full, then in_stall rises.
`timescale 1ns / 1ps

module serial_line_editor_tokenizer_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       op,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       kind,
  output logic [7:0] out_byte,
  output logic [7:0] write_index,
  output logic       line_done,
  output logic       last
);

  logic           q_full;
  logic           push;
  slet_pkg::job_t push_job;
  logic           pop;
  logic           q_valid;
  slet_pkg::job_t q_head;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  // Decode and line state.
  slet_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .op        (op),
    .rx_byte   (rx_byte),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  // Jobs waiting for the back part.
  slet_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  // Result sequencing.
  slet_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .out_byte    (out_byte),
    .write_index (write_index),
    .line_done   (line_done),
    .last        (last)
  );

endmodule

@@ rtl/slet_checker.sv @@
// Port-level checker for the serial line editor, bound to the top level.
// Depends on slet_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "serial_line_editor_tokenizer_top_assert.svh"

module slet_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       kind,
  input logic [7:0] out_byte,
  input logic [7:0] write_index,
  input logic       line_done,
  input logic       last
);

  logic [18:0] out_word;
  logic        term_ok;
  logic        is_echo;
  logic        echo_ok;

  // Whole result payload, and the forms of terminator and echo results.
  assign out_word = {kind, out_byte, write_index, line_done, last};
  assign term_ok  = (kind == slet_pkg::KIND_WRITE) && (out_byte == 8'd0) && last;
  assign is_echo  = (kind == slet_pkg::KIND_ECHO);
  assign echo_ok  = (write_index == 8'd0) && !line_done;

  // A stalled result item stays offered.
  `SLET_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

  // A stalled result item keeps its payload.
  `SLET_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_word), "stalled result changed")

  // The terminator is a zero write and always the final result of its item.
  `SLET_ASSERT_SAME(a_term_form, out_valid && line_done, term_ok, "malformed terminator")

  // Echo results carry no buffer position.
  `SLET_ASSERT_SAME(a_echo_index, out_valid && is_echo, echo_ok, "echo with index or done")

endmodule

bind serial_line_editor_tokenizer_top slet_checker u_slet_checker (.*);
